FILE: design/gart_pkg.sv
`default_nettype none

package gart_pkg;

  // table geometry
  localparam int MAX_REGIONS = 16;
  localparam int IDX_W       = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int COUNT_W     = $clog2(MAX_REGIONS + 1);
  localparam int USED_W      = 5;

  // transaction kinds
  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_ADD    = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] guest_address;
    logic [63:0] host_address;
    logic [63:0] span;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic [63:0]       translated;
    logic [USED_W-1:0] regions_used;
  } rsp_t;

  // one stored region
  typedef struct packed {
    logic [63:0] guest_start;
    logic [63:0] host_start;
    logic [63:0] length;
  } region_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic add;
    logic clear;
    logic fail;
    logic hit;
    logic scan_start;
    logic issue;
    logic post;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] kind;
    logic       zero_span;
    logic       empty;
    logic       rd_done;
    logic       hit;
    logic       miss;
    logic       out_free;
  } status_t;

endpackage

`default_nettype wire

FILE: design/guest_address_range_translator.sv
`default_nettype none

// guest address range translator: keeps a table of up to MAX_REGIONS regions
// (guest base, host base, length) in insertion order and handles one
// transaction at a time. kind add appends a region unless the table is full,
// the length is zero or either base plus length passes the top of the 64-bit
// space; kind clear empties the table; kind lookup walks the regions in order
// and the first region holding the guest address decides the result, ok only
// when the whole span fits in it, with translated = host base + offset. a
// zero span always fails, a reserved kind returns ok 0. every transaction
// gives exactly one result carrying the region count after it. add, clear,
// reserved kinds and lookups with a zero span or on an empty table go
// straight to the result without a scan; any other lookup scans the table
// through the single read port of the region table, read one entry a cycle,
// and a two-stage compare behind it, and stops at the first hit or after
// the last region. a transaction whose result finds the output register
// still stalled waits in its last state until the register frees. the
// result sits in an output register, so a new transaction is taken while
// the previous result waits on rsp_stall. the table needs no clearing
// pass after reset.

module guest_address_range_translator
  import gart_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  // command and status between the sequencer and the table datapath
  cmd_t    cmd;
  status_t status;

  // sequencer: accepts a transaction, steps the table scan, posts the result
  gart_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: region table, add checks, compare pipeline, output register
  gart_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .cmd      (cmd),
    .status   (status),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

endmodule

`default_nettype wire

FILE: design/gart_ram.sv
`default_nettype none

module gart_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: design/gart_dp.sv
`default_nettype none

module gart_dp
  import gart_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire req_t    req,
  input  wire cmd_t    cmd,
  output status_t      status,
  output logic         rsp_valid,
  input  wire logic    rsp_stall,
  output rsp_t         rsp
);

  req_t               req_r;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] rd_idx;
  logic               v1;
  logic               v2;
  region_t            rd_region;
  region_t            wr_region;
  logic               add_ok;
  logic [64:0]        g_end;
  logic [64:0]        h_end;

  // compare stage one
  logic [64:0] off_full;
  logic        s1_ge;
  logic [63:0] s1_off;
  logic [63:0] s1_len;
  logic [63:0] s1_hbase;

  // compare stage two
  logic        s2_in;
  logic [64:0] s2_end;
  logic        s2_fits;
  logic [63:0] s2_host;

  logic        res_ok;
  logic [63:0] res_trans;

  assign g_end  = {1'b0, req_r.guest_address} + {1'b0, req_r.span};
  assign h_end  = {1'b0, req_r.host_address} + {1'b0, req_r.span};
  assign add_ok = (count < COUNT_W'(MAX_REGIONS)) && (req_r.span != 64'd0)
                  && !g_end[64] && !h_end[64];

  assign wr_region = '{guest_start: req_r.guest_address,
                       host_start:  req_r.host_address,
                       length:      req_r.span};

  gart_ram #(
    .WIDTH($bits(region_t)),
    .DEPTH(MAX_REGIONS)
  ) u_table (
    .clk  (clk),
    .we   (cmd.add && add_ok),
    .waddr(count[IDX_W-1:0]),
    .wdata(wr_region),
    .raddr(rd_idx[IDX_W-1:0]),
    .rdata(rd_region)
  );

  assign off_full = {1'b0, req_r.guest_address} - {1'b0, rd_region.guest_start};

  assign s2_in   = s1_ge && (s1_off < s1_len);
  assign s2_end  = {1'b0, s1_off} + {1'b0, req_r.span};
  assign s2_fits = s2_end <= {1'b0, s1_len};
  assign s2_host = s1_hbase + s1_off;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= req;
    end
    s1_ge    <= !off_full[64];
    s1_off   <= off_full[63:0];
    s1_len   <= rd_region.length;
    s1_hbase <= rd_region.host_start;
    if (cmd.add) begin
      res_ok    <= add_ok;
      res_trans <= 64'd0;
    end else if (cmd.clear) begin
      res_ok    <= 1'b1;
      res_trans <= 64'd0;
    end else if (cmd.fail) begin
      res_ok    <= 1'b0;
      res_trans <= 64'd0;
    end else if (cmd.hit) begin
      res_ok    <= s2_fits;
      res_trans <= s2_fits ? s2_host : 64'd0;
    end
    if (cmd.post) begin
      rsp <= '{ok: res_ok, translated: res_trans, regions_used: USED_W'(count)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rd_idx    <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.clear) begin
        count <= '0;
      end else if (cmd.add && add_ok) begin
        count <= count + COUNT_W'(1);
      end
      if (cmd.scan_start) begin
        rd_idx <= '0;
        v1     <= 1'b0;
        v2     <= 1'b0;
      end else begin
        if (cmd.issue) begin
          rd_idx <= rd_idx + COUNT_W'(1);
        end
        v1 <= cmd.issue;
        v2 <= v1;
      end
      if (cmd.post) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign status = '{kind:      req_r.kind,
                    zero_span: req_r.span == 64'd0,
                    empty:     count == '0,
                    rd_done:   rd_idx == count,
                    hit:       v2 && s2_in,
                    miss:      v2 && !s2_in && !v1 && (rd_idx == count),
                    out_free:  !rsp_valid || !rsp_stall};

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(MAX_REGIONS))
    else $error("region count above table size");

  a_hit_miss: assert property (@(posedge clk) disable iff (rst)
    !(status.hit && status.miss))
    else $error("scan reports hit and miss at once");

  a_post_free: assert property (@(posedge clk) disable iff (rst)
    cmd.post |-> !rsp_valid || !rsp_stall)
    else $error("result posted over a stalled result");
`endif

endmodule

`default_nettype wire

FILE: design/gart_ctrl.sv
`default_nettype none

module gart_ctrl
  import gart_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    req_valid,
  output logic         req_stall,
  input  wire status_t status,
  output cmd_t         cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DECODE = 4'b0010,
    S_SCAN   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_FINISH;
        unique case (status.kind)
          KIND_ADD:   cmd.add   = 1'b1;
          KIND_CLEAR: cmd.clear = 1'b1;
          KIND_LOOKUP: begin
            if (status.zero_span || status.empty) begin
              cmd.fail = 1'b1;
            end else begin
              cmd.scan_start = 1'b1;
              state_next     = S_SCAN;
            end
          end
          default: cmd.fail = 1'b1;
        endcase
      end
      S_SCAN: begin
        cmd.issue = !status.rd_done;
        if (status.hit) begin
          cmd.hit    = 1'b1;
          state_next = S_FINISH;
        end else if (status.miss) begin
          cmd.fail   = 1'b1;
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.post   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef ASSERT_OFF
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.add, cmd.clear, cmd.fail, cmd.hit}))
    else $error("more than one result source in a cycle");

  a_post_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.post |=> !req_stall)
    else $error("controller not idle after posting a result");

  a_load_decode: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_DECODE)
    else $error("accepted transaction not decoded next cycle");
`endif

endmodule

`default_nettype wire
